[src/shl_pkg.sv]
`default_nettype none

package shl_pkg;

	// Table geometry. The slot count must be a power of two: the hash and
	// the probe wrap take the low bits of the byte sum and of the slot number.
	localparam int HASH_SLOTS    = 256;
	localparam int SLOT_W        = $clog2(HASH_SLOTS);
	localparam int USED_W        = SLOT_W + 1;
	localparam int NAME_CHARS    = 8;
	localparam int NAME_W        = 64;
	localparam int KEYWORD_COUNT = 23;
	localparam int KW_INDEX_W    = 5;
	localparam int OUTCOME_W     = 2;
	localparam int SLOT_INDEX_W  = 8;

	// The byte sum of eight characters needs 11 bits; it is kept at least as
	// wide as a slot number so the hash can always take its low bits.
	localparam int SUM_W         = (SLOT_W > 11) ? SLOT_W : 11;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam logic [NAME_W-1:0] NAME_MASK = (NAME_CHARS >= 8) ? {NAME_W{1'b1}} :
		((NAME_W'(1) << (8 * NAME_CHARS)) - NAME_W'(1));

	localparam logic [OUTCOME_W-1:0] OUTCOME_FOUND    = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_KEYWORD  = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_OVERFLOW = 2'd3;

	typedef logic [NAME_W-1:0] name_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// Keyword spellings, byte 0 in the low bits, zero padded.
	localparam name_t KEYWORDS [KEYWORD_COUNT] = '{
		64'h0000_0000_0074_6E69,  // int
		64'h0000_0000_7261_6863,  // char
		64'h0000_0074_616F_6C66,  // float
		64'h0000_656C_6275_6F64,  // double
		64'h0000_7463_7572_7473,  // struct
		64'h0000_0000_676E_6F6C,  // long
		64'h0000_0000_6F74_7561,  // auto
		64'h0000_6E72_6574_7865,  // extern
		64'h0000_6369_7461_7473,  // static
		64'h7265_7473_6967_6572,  // register
		64'h0000_0000_6F74_6F67,  // goto
		64'h0000_6E72_7574_6572,  // return
		64'h0000_0000_0000_6669,  // if
		64'h0000_0065_6C69_6877,  // while
		64'h0000_0000_6573_6C65,  // else
		64'h0000_6863_7469_7773,  // switch
		64'h0000_0000_6573_6163,  // case
		64'h0000_006B_6165_7262,  // break
		64'h6575_6E69_746E_6F63,  // continue
		64'h0000_0000_0000_6F64,  // do
		64'h0074_6C75_6166_6564,  // default
		64'h0000_0000_0072_6F66,  // for
		64'h0000_666F_657A_6973   // sizeof
	};

	// Byte sum of a name, leaving out a leading dot, reduced to a slot number.
	function automatic slot_t hash_f(input name_t name);
		logic [SUM_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (!(i == 0 && name[7:0] == DOT_CHAR)) begin
				sum = sum + SUM_W'(name[8*i +: 8]);
			end
		end
		return sum[SLOT_W-1:0];
	endfunction

	// Number of characters before the first zero byte.
	function automatic logic [3:0] kw_len_f(input name_t kw);
		logic [3:0] len;
		logic       stop;
		len  = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!stop && kw[8*i +: 8] != 8'h00) begin
				len = len + 4'd1;
			end else begin
				stop = 1'b1;
			end
		end
		return len;
	endfunction

	// Home slots of all keywords, as one bit per slot.
	function automatic logic [HASH_SLOTS-1:0] kw_marks_f();
		logic [HASH_SLOTS-1:0] marks;
		marks = '0;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			marks[hash_f(KEYWORDS[k])] = 1'b1;
		end
		return marks;
	endfunction

	localparam logic [HASH_SLOTS-1:0] KW_MARKS = kw_marks_f();

	// Compares a name, after an optional leading dot, with one keyword.
	// The compare ends with a hit at the first zero byte that matches; a name
	// that fills its window without a zero hits only a keyword of that length.
	function automatic logic kw_match_f(input name_t name, input name_t kw);
		name_t      body;
		logic [3:0] window;
		logic       fail;
		logic       hit;
		logic       stop;
		body   = (name[7:0] == DOT_CHAR) ? (name >> 8) : name;
		window = (name[7:0] == DOT_CHAR) ? 4'(NAME_CHARS - 1) : 4'(NAME_CHARS);
		fail   = 1'b0;
		hit    = 1'b0;
		stop   = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!stop && 4'(i) < window) begin
				if (body[8*i +: 8] != kw[8*i +: 8]) begin
					fail = 1'b1;
					stop = 1'b1;
				end else if (body[8*i +: 8] == 8'h00) begin
					hit  = 1'b1;
					stop = 1'b1;
				end
			end
		end
		return !fail && (hit || kw_len_f(kw) == window);
	endfunction

endpackage

`default_nettype wire

[src/symbol_hash_table_lookup.sv]
`default_nettype none

// Symbol table lookup with keyword screening.
// Input channel: symbol_name with in_valid/in_ready. One transaction carries
// one identifier of up to eight bytes, byte 0 in the low bits, zero padded.
// Output channel: outcome, slot_index and keyword_index with
// out_valid/out_ready. Every input transaction yields exactly one output
// transaction: found, inserted, keyword or table overflow.
// Configuration: cfg_we writes cfg_wdata into the new-entry flag, which is
// ORed into the flag of every slot that an insert fills.
// Timing: the block works on one name at a time. A keyword hit passes from
// acceptance through the done state into the output register; a table lookup
// first probes slots from the home slot on, walking the name memory one
// synchronous read per cycle, and then passes through the done state. in_ready
// returns in the cycle the result appears in the output register.
// Stalls: the result sits in an output register. While it waits for
// out_ready the next name is still accepted and probed; only the hand-over
// of that next result waits for the output register to drain.
// Reset: arst_n clears the control state, the used count, the flag register
// and the per-slot valid bits, so the table reads as empty at once and no
// clearing pass is needed.
module symbol_hash_table_lookup
	import shl_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_wdata,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic [NAME_W-1:0]       symbol_name,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic [OUTCOME_W-1:0]    outcome,
	output      logic [SLOT_INDEX_W-1:0] slot_index,
	output      logic [KW_INDEX_W-1:0]   keyword_index
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_DONE  = 2'd2;

	// Name and flag memories with a registered read: data appears in the cycle after the address is presented.
	name_t names_mem [HASH_SLOTS];
	logic  flags_mem [HASH_SLOTS];

	logic [1:0]            state_q;
	logic                  new_flag_q;
	logic [HASH_SLOTS-1:0] valid_q;
	logic [USED_W-1:0]     used_q;
	name_t                 name_q;
	slot_t                 slot_q;
	slot_t                 probes_q;
	name_t                 rd_name_q;
	logic                  rd_flag_q;

	logic [OUTCOME_W-1:0]  res_outcome_q;
	slot_t                 res_slot_q;
	logic [KW_INDEX_W-1:0] res_kw_q;

	logic                  out_valid_q;
	logic [OUTCOME_W-1:0]  outcome_q;
	logic [SLOT_INDEX_W-1:0] slot_index_q;
	logic [KW_INDEX_W-1:0] keyword_index_q;

	name_t                 name_in;
	slot_t                 home_slot;
	logic                  kw_hit;
	logic [KW_INDEX_W-1:0] kw_idx;
	slot_t                 rd_addr;
	name_t                 cur_name;
	logic                  cur_flag;
	logic                  cur_empty;
	logic                  cur_match;
	logic                  table_full;
	logic                  do_insert;
	logic                  accept;
	logic                  out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign name_in   = symbol_name & NAME_MASK;
	assign home_slot = hash_f(name_in);

	// Keyword screen: the first keyword in table order that matches wins,
	// and it counts only when the home slot carries a keyword mark.
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (!kw_hit && kw_match_f(name_in, KEYWORDS[k])) begin
				kw_hit = 1'b1;
				kw_idx = KW_INDEX_W'(k);
			end
		end
		kw_hit = kw_hit && KW_MARKS[home_slot];
	end

	// While probing, the next slot is fetched ahead of the compare.
	assign rd_addr = (state_q == S_IDLE) ? home_slot : slot_q + slot_t'(1);

	// A slot never written since reset reads as an all-zero empty entry.
	assign cur_name   = valid_q[slot_q] ? rd_name_q : '0;
	assign cur_flag   = valid_q[slot_q] ? rd_flag_q : 1'b0;
	assign cur_empty  = (cur_name[7:0] == 8'h00);
	assign cur_match  = (cur_name == name_q);
	assign table_full = (used_q >= USED_W'(HASH_SLOTS - 1));
	assign do_insert  = (state_q == S_PROBE) && cur_empty && !table_full;

	always_ff @(posedge clk) begin
		rd_name_q <= names_mem[rd_addr];
		rd_flag_q <= flags_mem[rd_addr];
		if (do_insert) begin
			names_mem[slot_q] <= name_q;
			flags_mem[slot_q] <= cur_flag | new_flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (do_insert) begin
			valid_q[slot_q] <= 1'b1;
			used_q          <= used_q + USED_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_flag_q <= 1'b0;
		end else if (cfg_we) begin
			new_flag_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= kw_hit ? S_DONE : S_PROBE;
					end
				end
				S_PROBE: begin
					if (cur_empty || cur_match || probes_q == '1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				name_q        <= name_in;
				slot_q        <= home_slot;
				probes_q      <= '0;
				res_outcome_q <= OUTCOME_KEYWORD;
				res_slot_q    <= '0;
				res_kw_q      <= kw_idx;
			end
			S_PROBE: begin
				res_kw_q <= '0;
				if (cur_empty) begin
					res_outcome_q <= table_full ? OUTCOME_OVERFLOW : OUTCOME_INSERTED;
					res_slot_q    <= table_full ? '0 : slot_q;
				end else if (cur_match) begin
					res_outcome_q <= OUTCOME_FOUND;
					res_slot_q    <= slot_q;
				end else begin
					// Occupied slot without a match: probe on; overflow stands if no slot is left.
					res_outcome_q <= OUTCOME_OVERFLOW;
					res_slot_q    <= '0;
					slot_q        <= slot_q + slot_t'(1);
					probes_q      <= probes_q + slot_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			outcome_q       <= res_outcome_q;
			slot_index_q    <= SLOT_INDEX_W'(res_slot_q);
			keyword_index_q <= res_kw_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign slot_index    = slot_index_q;
	assign keyword_index = keyword_index_q;

endmodule

`default_nettype wire
